// ===== design/lpc_pkg.sv =====
// ----------------------------------------------------------------------------
// lpc_pkg: shared definitions for the LRU plan cache
// Request codes, fixed field widths, parameter defaults and the control
// bundle that the top level broadcasts to every cache cell.
// ----------------------------------------------------------------------------
package lpc_pkg;

  // Request kinds carried in the input tuser field
  localparam logic [1:0] REQ_LOOKUP     = 2'd0;
  localparam logic [1:0] REQ_INSERT     = 2'd1;
  localparam logic [1:0] REQ_INVALIDATE = 2'd2;

  localparam int REQ_W   = 2;   // request kind width
  localparam int CFG_W   = 7;   // max_entries register width
  localparam int COUNT_W = 7;   // entry_count / evicted_count result width
  localparam int APB_W   = 32;  // config data width
  localparam int PADDR_W = 3;   // byte address, one 32-bit register

  // Register indexes (byte address / 4)
  localparam logic REG_MAX_ENTRIES = 1'b0;

  // Parameter defaults
  localparam int CAPACITY_DEF    = 64;
  localparam int KEY_BITS_DEF    = 64;
  localparam int HANDLE_BITS_DEF = 32;

  localparam logic [CFG_W-1:0] MAX_ENTRIES_RST = 7'd64;

  // Control broadcast to the cell row
  typedef struct packed {
    logic capture;    // latch key compare for the request being accepted
    logic commit;     // apply the recency move in the update cycle
    logic shift_all;  // insert miss: every cell takes its neighbor's entry
  } cell_ctrl_t;

endpackage

// ===== design/lru_plan_cache_top.sv =====
// ----------------------------------------------------------------------------
// lru_plan_cache_top: fully associative LRU cache of 64-bit keys to handles
// Request stream in (lookup / insert / invalidate), one result per request.
// ----------------------------------------------------------------------------
// Each request has an accept cycle, in which every
// cell compares its key against the request key, and an update cycle, in
// which the row of cells reorders by recency and the result is registered.
// The next request is accepted once the update is done, so a new request
// cannot be taken while one is still in flight; a result left waiting on a stalled
// output holds the update cycle until the output register frees up. Cells
// are kept in recency order (cell 0 is most recent), so eviction simply
// shortens the live count and no clearing pass is needed after reset.
module lru_plan_cache_top #(
  parameter int CAPACITY    = lpc_pkg::CAPACITY_DEF,
  parameter int KEY_BITS    = lpc_pkg::KEY_BITS_DEF,
  parameter int HANDLE_BITS = lpc_pkg::HANDLE_BITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  // Request stream
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // tdata: key, plan_handle (zero padded to bytes)
  input  logic [((KEY_BITS+HANDLE_BITS+7)/8)*8-1:0]   s_axis_tdata,
  // tuser: req_type
  input  logic [lpc_pkg::REQ_W-1:0]                   s_axis_tuser,
  // Result stream
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // tdata: handle_out, entry_count, evicted_count (zero padded to bytes)
  output logic [((HANDLE_BITS+2*lpc_pkg::COUNT_W+7)/8)*8-1:0] m_axis_tdata,
  // tuser: hit
  output logic                                        m_axis_tuser,
  // Configuration port
  input  logic                                        psel,
  input  logic                                        penable,
  input  logic                                        pwrite,
  input  logic [lpc_pkg::PADDR_W-1:0]                 paddr,
  input  logic [lpc_pkg::APB_W-1:0]                   pwdata,
  output logic [lpc_pkg::APB_W-1:0]                   prdata,
  output logic                                        pready
);
  import lpc_pkg::*;

  localparam int IN_W  = ((KEY_BITS + HANDLE_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((HANDLE_BITS + 2 * COUNT_W + 7) / 8) * 8;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CW    = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  // --------------------------------------------------------------------------
  // Configuration register
  logic [CFG_W-1:0] max_entries_q, max_entries_d;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    max_entries_d = max_entries_q;
    if (cfg_wr && paddr[2] == REG_MAX_ENTRIES) begin
      max_entries_d = pwdata[CFG_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_MAX_ENTRIES) ? APB_W'(max_entries_q) : '0;

  // Effective limit: zero acts as one, saturate at capacity
  logic [CW-1:0] lim_ext;
  always_comb begin
    if (max_entries_q == '0) begin
      lim_ext = CW'(1);
    end else if (CW'(max_entries_q) > CW'(CAPACITY)) begin
      lim_ext = CW'(CAPACITY);
    end else begin
      lim_ext = CW'(max_entries_q);
    end
  end

  // --------------------------------------------------------------------------
  // Request capture
  logic                   state_q, state_d;
  logic [REQ_W-1:0]       req_q, req_d;
  logic [KEY_BITS-1:0]    req_key_q, req_key_d;
  logic [HANDLE_BITS-1:0] req_handle_q, req_handle_d;
  logic [CNT_W-1:0]       count_q, count_d;
  logic [CNT_W-1:0]       live_q, live_d;
  logic                   in_acc;
  logic                   commit;
  logic [KEY_BITS-1:0]    in_key;
  logic [HANDLE_BITS-1:0] in_handle;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign in_key        = s_axis_tdata[KEY_BITS-1:0];
  assign in_handle     = s_axis_tdata[KEY_BITS+HANDLE_BITS-1:KEY_BITS];

  // Output register free or draining this cycle
  assign commit = (state_q == ST_EXEC) & (~m_axis_tvalid | m_axis_tready);

  always_comb begin
    req_d        = req_q;
    req_key_d    = req_key_q;
    req_handle_d = req_handle_q;
    live_d       = live_q;
    if (in_acc) begin
      req_d        = s_axis_tuser;
      req_key_d    = in_key;
      req_handle_d = in_handle;
      // Entries that survive the pre-insert eviction
      if (s_axis_tuser == REQ_INSERT && CW'(count_q) >= lim_ext) begin
        live_d = CNT_W'(lim_ext - CW'(1));
      end else begin
        live_d = count_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Cell row
  cell_ctrl_t             ctrl;
  logic                   any_hit;
  logic [KEY_BITS-1:0]    cell_key [CAPACITY];
  logic [HANDLE_BITS-1:0] cell_handle [CAPACITY];
  logic [HANDLE_BITS-1:0] cell_sel [CAPACITY];
  logic                   pass [CAPACITY+1];
  logic [HANDLE_BITS-1:0] sel_handle;
  logic [HANDLE_BITS-1:0] front_handle;
  logic                   is_lookup, is_insert;

  assign is_lookup      = (req_q == REQ_LOOKUP);
  assign is_insert      = (req_q == REQ_INSERT);
  assign pass[CAPACITY] = 1'b0;
  assign any_hit        = pass[0];

  assign ctrl.capture   = in_acc;
  assign ctrl.commit    = commit & (is_lookup | is_insert);
  assign ctrl.shift_all = is_insert & ~any_hit;

  // Hit handle: at most one cell drives a nonzero value
  always_comb begin
    sel_handle = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      sel_handle = sel_handle | cell_sel[i];
    end
  end

  assign front_handle = is_insert ? req_handle_q : sel_handle;

  for (genvar j = 0; j < CAPACITY; j++) begin : g_cell
    logic [KEY_BITS-1:0]    prev_key;
    logic [HANDLE_BITS-1:0] prev_handle;
    if (j == 0) begin : g_head
      assign prev_key    = req_key_q;
      assign prev_handle = front_handle;
    end else begin : g_body
      assign prev_key    = cell_key[j-1];
      assign prev_handle = cell_handle[j-1];
    end

    lpc_cell #(
      .IDX         (j),
      .CNT_W       (CNT_W),
      .KEY_BITS    (KEY_BITS),
      .HANDLE_BITS (HANDLE_BITS)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .req_key_i     (in_key),
      .live_cnt_i    (live_q),
      .prev_key_i    (prev_key),
      .prev_handle_i (prev_handle),
      .pass_i        (pass[j+1]),
      .pass_o        (pass[j]),
      .key_o         (cell_key[j]),
      .handle_o      (cell_handle[j]),
      .sel_handle_o  (cell_sel[j])
    );
  end

  // --------------------------------------------------------------------------
  // Update cycle: count and result
  logic                   out_valid_q, out_valid_d;
  logic                   out_hit_q, out_hit_d;
  logic [HANDLE_BITS-1:0] out_handle_q, out_handle_d;
  logic [COUNT_W-1:0]     out_count_q, out_count_d;
  logic [COUNT_W-1:0]     out_evict_q, out_evict_d;
  logic [CNT_W-1:0]       new_count;
  logic [CNT_W-1:0]       evicted;

  always_comb begin
    new_count = count_q;
    evicted   = '0;
    case (req_q)
      REQ_LOOKUP: begin
        new_count = count_q;
      end
      REQ_INSERT: begin
        new_count = any_hit ? live_q : live_q + CNT_W'(1);
        evicted   = count_q - live_q;
      end
      REQ_INVALIDATE: begin
        new_count = '0;
        evicted   = count_q;
      end
      default: begin
        new_count = count_q;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q;
    out_hit_d    = out_hit_q;
    out_handle_d = out_handle_q;
    out_count_d  = out_count_q;
    out_evict_d  = out_evict_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (in_acc) begin
      state_d = ST_EXEC;
    end
    if (commit) begin
      state_d      = ST_IDLE;
      count_d      = new_count;
      out_valid_d  = 1'b1;
      out_hit_d    = is_lookup & any_hit;
      out_handle_d = (is_lookup & any_hit) ? sel_handle : '0;
      out_count_d  = COUNT_W'(new_count);
      out_evict_d  = COUNT_W'(evicted);
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      count_q       <= '0;
      out_valid_q   <= 1'b0;
      max_entries_q <= MAX_ENTRIES_RST;
    end else begin
      state_q       <= state_d;
      count_q       <= count_d;
      out_valid_q   <= out_valid_d;
      max_entries_q <= max_entries_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    req_key_q    <= req_key_d;
    req_handle_q <= req_handle_d;
    live_q       <= live_d;
    out_hit_q    <= out_hit_d;
    out_handle_q <= out_handle_d;
    out_count_q  <= out_count_d;
    out_evict_q  <= out_evict_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_hit_q;
  assign m_axis_tdata  = OUT_W'({out_evict_q, out_count_q, out_handle_q});

endmodule

// ===== design/lpc_cell.sv =====
// ----------------------------------------------------------------------------
// lpc_cell: one entry of the recency-ordered cache row
// Holds one key and handle. Cell position equals recency rank (cell 0 is
// most recent). A move to front shifts each cell above the hole down by one.
// ----------------------------------------------------------------------------
module lpc_cell #(
  parameter int IDX         = 0,
  parameter int CNT_W       = 7,
  parameter int KEY_BITS    = lpc_pkg::KEY_BITS_DEF,
  parameter int HANDLE_BITS = lpc_pkg::HANDLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  lpc_pkg::cell_ctrl_t    ctrl_i,
  input  logic [KEY_BITS-1:0]    req_key_i,     // broadcast compare key
  input  logic [CNT_W-1:0]       live_cnt_i,    // entries still valid
  input  logic [KEY_BITS-1:0]    prev_key_i,    // from the more recent neighbor
  input  logic [HANDLE_BITS-1:0] prev_handle_i,
  input  logic                   pass_i,        // a hit sits in an older cell
  output logic                   pass_o,        // a hit sits here or older
  output logic [KEY_BITS-1:0]    key_o,
  output logic [HANDLE_BITS-1:0] handle_o,
  output logic [HANDLE_BITS-1:0] sel_handle_o   // own handle when hit, else 0
);
  import lpc_pkg::*;

  logic [KEY_BITS-1:0]    key_q, key_d;
  logic [HANDLE_BITS-1:0] handle_q, handle_d;
  logic                   match_q, match_d;
  logic                   hit_here;

  // Key compare is captured with the request
  assign match_d  = ctrl_i.capture ? (key_q == req_key_i) : match_q;

  // Only cells inside the live range count as hits
  assign hit_here = match_q & (CNT_W'(IDX) < live_cnt_i);
  assign pass_o   = hit_here | pass_i;

  // Take the neighbor's entry when the hole is here or in an older cell
  always_comb begin
    key_d    = key_q;
    handle_d = handle_q;
    if (ctrl_i.commit && (ctrl_i.shift_all || pass_o)) begin
      key_d    = prev_key_i;
      handle_d = prev_handle_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q    <= key_d;
    handle_q <= handle_d;
    match_q  <= match_d;
  end

  assign key_o        = key_q;
  assign handle_o     = handle_q;
  assign sel_handle_o = hit_here ? handle_q : '0;

endmodule

// ===== bench/lru_plan_cache_checker.sv =====
// ----------------------------------------------------------------------------
// lru_plan_cache_checker: prediction and result checking for the LRU cache
// Watches the request, result and configuration ports, keeps its own copy
// of the cache table, and compares every result against the oldest
// outstanding prediction. The failure count goes back to the testbench top.
// ----------------------------------------------------------------------------
module lru_plan_cache_checker
  import lpc_pkg::*;
#(
  parameter int CAPACITY    = CAPACITY_DEF,
  parameter int KEY_BITS    = KEY_BITS_DEF,
  parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  // Request channel
  input  logic                                         s_axis_tvalid,
  input  logic                                         s_axis_tready,
  // tdata: key, plan_handle
  input  logic [((KEY_BITS+HANDLE_BITS+7)/8)*8-1:0]    s_axis_tdata,
  // tuser: req_type
  input  logic [REQ_W-1:0]                             s_axis_tuser,
  // Result channel
  input  logic                                         m_axis_tvalid,
  input  logic                                         m_axis_tready,
  // tdata: handle_out, entry_count, evicted_count
  input  logic [((HANDLE_BITS+2*COUNT_W+7)/8)*8-1:0]   m_axis_tdata,
  // tuser: hit
  input  logic                                         m_axis_tuser,
  // Configuration port
  input  logic                                         psel,
  input  logic                                         penable,
  input  logic                                         pwrite,
  input  logic [PADDR_W-1:0]                           paddr,
  input  logic [APB_W-1:0]                             pwdata,
  input  logic [APB_W-1:0]                             prdata,
  input  logic                                         pready,
  // Status back to the testbench
  output int                                           fail_cnt_o,
  output int                                           pending_o,
  output int                                           checked_o,
  output int                                           hits_o,
  output int                                           evicted_o,
  output int                                           peak_o
);

  // Result field positions in m_axis_tdata
  localparam int HO_LSB = 0;
  localparam int EC_LSB = HANDLE_BITS;
  localparam int EV_LSB = HANDLE_BITS + COUNT_W;

  typedef struct {
    logic                   hit;
    logic [HANDLE_BITS-1:0] handle;
    logic [COUNT_W-1:0]     entries;
    logic [COUNT_W-1:0]     evicted;
  } cache_result_t;

  // Shadow copy of the cache table; age 0 is most recent
  logic                   line_valid  [CAPACITY];
  logic [KEY_BITS-1:0]    line_key    [CAPACITY];
  logic [HANDLE_BITS-1:0] line_handle [CAPACITY];
  int                     line_age    [CAPACITY];
  int                     live_count = 0;
  logic [CFG_W-1:0]       limit_reg  = MAX_ENTRIES_RST;

  cache_result_t expected_q [$];
  cache_result_t want;
  cache_result_t pred;

  int fail_n    = 0;
  int pend_n    = 0;
  int checked_n = 0;
  int hits_n    = 0;
  int evicted_n = 0;
  int peak_n    = 0;

  assign fail_cnt_o = fail_n;
  assign pending_o  = pend_n;
  assign checked_o  = checked_n;
  assign hits_o     = hits_n;
  assign evicted_o  = evicted_n;
  assign peak_o     = peak_n;

  function automatic int find_line(logic [KEY_BITS-1:0] tag);
    for (int i = 0; i < CAPACITY; i++) begin
      if (line_valid[i] && line_key[i] == tag) return i;
    end
    return -1;
  endfunction

  // Move one line to most recent, aging everything that was newer
  function automatic void promote(int slot);
    int old_age;
    old_age = line_age[slot];
    for (int i = 0; i < CAPACITY; i++) begin
      if (line_valid[i] && line_age[i] < old_age) line_age[i]++;
    end
    line_age[slot] = 0;
  endfunction

  function automatic bit drop_oldest();
    if (live_count == 0) return 1'b0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (line_valid[i] && line_age[i] == live_count - 1) begin
        line_valid[i] = 1'b0;
        live_count--;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Apply one request to the shadow table and return the result it gives
  function automatic cache_result_t apply_request(logic [REQ_W-1:0] kind,
                                                  logic [KEY_BITS-1:0] tag,
                                                  logic [HANDLE_BITS-1:0] hval);
    cache_result_t res;
    int slot, lim, dropped;
    res.hit    = 1'b0;
    res.handle = '0;
    dropped    = 0;
    case (kind)
      REQ_LOOKUP: begin
        slot = find_line(tag);
        if (slot >= 0) begin
          res.hit    = 1'b1;
          res.handle = line_handle[slot];
          promote(slot);
        end
      end
      REQ_INSERT: begin
        // limit 0 behaves as 1, anything past the table size saturates
        lim = (limit_reg < 1) ? 1 : (limit_reg > CAPACITY ? CAPACITY : int'(limit_reg));
        while (live_count >= lim && drop_oldest()) dropped++;
        slot = find_line(tag);
        if (slot >= 0) begin
          line_handle[slot] = hval;
          promote(slot);
        end else begin
          slot = -1;
          for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!line_valid[i]) slot = i;
          end
          if (slot >= 0) begin
            for (int j = 0; j < CAPACITY; j++) begin
              if (line_valid[j]) line_age[j]++;
            end
            line_valid[slot]  = 1'b1;
            line_key[slot]    = tag;
            line_handle[slot] = hval;
            line_age[slot]    = 0;
            live_count++;
          end
        end
      end
      REQ_INVALIDATE: begin
        dropped = live_count;
        for (int i = 0; i < CAPACITY; i++) line_valid[i] = 1'b0;
        live_count = 0;
      end
      default: ;  // unknown request leaves the table alone
    endcase
    res.entries = live_count[COUNT_W-1:0];
    res.evicted = dropped[COUNT_W-1:0];
    return res;
  endfunction

  task automatic flag_mismatch(string what, logic [63:0] exp_val, logic [63:0] got_val);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, exp_val, got_val);
    fail_n++;
  endtask

  // Sample all channels at the clock edge
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CAPACITY; i++) line_valid[i] = 1'b0;
      live_count = 0;
      limit_reg  = MAX_ENTRIES_RST;
      expected_q.delete();
      pend_n = 0;
    end else begin
      // Results: compare against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        checked_n++;
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected, hit %0b tdata 0x%0h",
                   $time, m_axis_tuser, m_axis_tdata);
          fail_n++;
        end else begin
          want = expected_q[0];
          expected_q.delete(0);
          if (m_axis_tuser !== want.hit)
            flag_mismatch("hit", 64'(want.hit), 64'(m_axis_tuser));
          if (m_axis_tdata[HO_LSB +: HANDLE_BITS] !== want.handle)
            flag_mismatch("handle_out", 64'(want.handle),
                          64'(m_axis_tdata[HO_LSB +: HANDLE_BITS]));
          if (m_axis_tdata[EC_LSB +: COUNT_W] !== want.entries)
            flag_mismatch("entry_count", 64'(want.entries),
                          64'(m_axis_tdata[EC_LSB +: COUNT_W]));
          if (m_axis_tdata[EV_LSB +: COUNT_W] !== want.evicted)
            flag_mismatch("evicted_count", 64'(want.evicted),
                          64'(m_axis_tdata[EV_LSB +: COUNT_W]));
          if (want.hit) hits_n++;
          evicted_n += int'(want.evicted);
          if (int'(want.entries) > peak_n) peak_n = int'(want.entries);
        end
      end

      // Requests: predict and queue
      if (s_axis_tvalid && s_axis_tready) begin
        pred = apply_request(s_axis_tuser,
                             s_axis_tdata[KEY_BITS-1:0],
                             s_axis_tdata[KEY_BITS +: HANDLE_BITS]);
        expected_q.insert(expected_q.size(), pred);
      end

      // Register access
      if (psel && penable && pready && paddr[PADDR_W-1:2] == REG_MAX_ENTRIES) begin
        if (pwrite) begin
          limit_reg = pwdata[CFG_W-1:0];
        end else if (prdata !== {{(APB_W-CFG_W){1'b0}}, limit_reg}) begin
          flag_mismatch("max_entries readback", 64'({{(APB_W-CFG_W){1'b0}}, limit_reg}),
                        64'(prdata));
        end
      end

      pend_n = expected_q.size();
    end
  end

endmodule

// ===== bench/lru_plan_cache_top_tb.sv =====
// ----------------------------------------------------------------------------
// lru_plan_cache_top_tb: stimulus and verdict for the LRU plan cache
// Runs a short directed sequence over the corner cases, then random traffic
// from per-phase key pools under a range of capacity limits, with bursty
// requests, a stalling result side and one long result hold-off.
// ----------------------------------------------------------------------------
module lru_plan_cache_top_tb;
  import lpc_pkg::*;

  localparam int KEY_BITS    = KEY_BITS_DEF;
  localparam int HANDLE_BITS = HANDLE_BITS_DEF;
  localparam int CAPACITY    = CAPACITY_DEF;
  localparam int IN_DATA_W   = ((KEY_BITS+HANDLE_BITS+7)/8)*8;
  localparam int OUT_DATA_W  = ((HANDLE_BITS+2*COUNT_W+7)/8)*8;

  localparam logic [REQ_W-1:0]   REQ_UNKNOWN      = 2'd3;
  localparam logic [PADDR_W-1:0] MAX_ENTRIES_ADDR = {REG_MAX_ENTRIES, 2'b00};

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int LONG_HOLD      = 400;
  localparam int HOLD_AFTER     = 500;
  localparam int NUM_PHASES     = 12;
  localparam int POOL_MAX       = 128;

  typedef enum int {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_DATA_W-1:0]   s_axis_tdata;   // key, plan_handle
  logic [REQ_W-1:0]       s_axis_tuser;   // req_type
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;   // handle_out, entry_count, evicted_count
  logic                   m_axis_tuser;   // hit
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [PADDR_W-1:0]     paddr;
  logic [APB_W-1:0]       pwdata;
  logic [APB_W-1:0]       prdata;
  logic                   pready;

  int fail_cnt, pending, checked, hits, evicted, peak;
  int reqs_sent   = 0;
  int limits_set  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;

  logic [KEY_BITS-1:0] key_pool [POOL_MAX];

  lru_plan_cache_top u_top (.*);

  lru_plan_cache_checker u_checker (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .fail_cnt_o (fail_cnt),
    .pending_o  (pending),
    .checked_o  (checked),
    .hits_o     (hits),
    .evicted_o  (evicted),
    .peak_o     (peak)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Send one request, then maybe end the burst with a gap
  task automatic send_req(logic [REQ_W-1:0] kind, logic [KEY_BITS-1:0] tag,
                          logic [HANDLE_BITS-1:0] hval);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {hval, tag};
    s_axis_tuser  <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    reqs_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // Stop sending until every predicted result has come back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // Setup and access phase; upper data bits are random filler
  task automatic apb_access(logic wr, logic [CFG_W-1:0] val);
    logic [APB_W-1:0] word;
    word = $urandom;
    word[CFG_W-1:0] = val;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= MAX_ENTRIES_ADDR;
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_limit(logic [CFG_W-1:0] val);
    drain();
    apb_access(1'b1, val);
    apb_access(1'b0, val);
    limits_set++;
  endtask

  // Result side: random stall patterns, plus one long hold-off mid-run
  initial begin
    rx_mode_e mode;
    int seg_len, tick;
    logic hold_done;
    hold_done = 1'b0;
    tick = 0;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (!hold_done && reqs_sent >= HOLD_AFTER) begin
        hold_done = 1'b1;
        repeat (LONG_HOLD) begin
          @(posedge clk_i);
          m_axis_tready <= 1'b0;
        end
      end else begin
        seg_len = $urandom_range(1, 40);
        mode = rx_mode_e'($urandom_range(0, 3));
        repeat (seg_len) begin
          @(posedge clk_i);
          case (mode)
            RX_OPEN:   m_axis_tready <= 1'b1;
            RX_MOSTLY: m_axis_tready <= ($urandom_range(0, 3) != 0);
            RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
            default:   m_axis_tready <= (tick % 3 != 0);
          endcase
          tick++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (psel && penable && pready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus
  initial begin
    int eff, pool_n, inv_odds, roll, insert_pct;
    logic [REQ_W-1:0] kind;
    logic [KEY_BITS-1:0] tag;
    logic [KEY_BITS-1:0] alt_key;
    int limit_plan [NUM_PHASES];

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_LOOKUP;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, extremes, update in place, unknown request
    alt_key = {(KEY_BITS/2){2'b01}};
    send_req(REQ_LOOKUP, '0, '0);
    send_req(REQ_INVALIDATE, '1, '1);
    send_req(REQ_UNKNOWN, '1, '1);
    send_req(REQ_INSERT, '0, '0);
    send_req(REQ_INSERT, '1, '1);
    send_req(REQ_LOOKUP, '1, '0);
    send_req(REQ_LOOKUP, '0, '1);
    send_req(REQ_INSERT, '0, 32'hA5A5_5A5A);
    send_req(REQ_LOOKUP, '0, '0);
    send_req(REQ_UNKNOWN, '0, '0);
    send_req(REQ_LOOKUP, alt_key, '0);
    send_req(REQ_INVALIDATE, '0, '0);
    send_req(REQ_LOOKUP, '1, '0);

    // Limit of one: each insert into a full table evicts, even a re-insert of the same key
    set_limit(7'd1);
    send_req(REQ_INSERT, alt_key, 32'd1);
    send_req(REQ_INSERT, ~alt_key, 32'd2);
    send_req(REQ_LOOKUP, alt_key, '0);
    send_req(REQ_INSERT, ~alt_key, 32'd3);
    send_req(REQ_LOOKUP, ~alt_key, '0);

    // Limit of zero acts as one
    set_limit(7'd0);
    send_req(REQ_INSERT, 64'd1, 32'd4);
    send_req(REQ_INSERT, 64'h8000_0000_0000_0000, 32'd5);

    // Limit of two: a lookup hit protects its entry from the next eviction
    set_limit(7'd2);
    send_req(REQ_INSERT, 64'd10, 32'd10);
    send_req(REQ_INSERT, 64'd11, 32'd11);
    send_req(REQ_LOOKUP, 64'd10, '0);
    send_req(REQ_INSERT, 64'd12, 32'd12);
    send_req(REQ_LOOKUP, 64'd11, '0);

    // Random phases; the large limits come first so the table fills to capacity
    limit_plan = '{127, 64, 1, 0, 2, 3, 65, 8, 0, 63, 100, 5};
    limit_plan[8] = $urandom_range(4, 60);
    for (int p = 0; p < NUM_PHASES; p++) begin
      set_limit(limit_plan[p][CFG_W-1:0]);
      eff = (limit_plan[p] < 1) ? 1 : (limit_plan[p] > CAPACITY ? CAPACITY : limit_plan[p]);
      pool_n = eff + $urandom_range(1, eff/2 + 2);
      if (pool_n > POOL_MAX) pool_n = POOL_MAX;
      for (int i = 0; i < pool_n; i++) key_pool[i] = {$urandom, $urandom};
      if ($urandom_range(0, 1) == 1) begin
        key_pool[0]        = '0;
        key_pool[pool_n-1] = '1;
      end
      inv_odds   = (eff >= 32) ? 400 : 40;
      insert_pct = (eff >= 32) ? 64 : 52;
      repeat ((eff >= 32) ? 260 : 60) begin
        if ($urandom_range(0, inv_odds - 1) == 0) begin
          kind = REQ_INVALIDATE;
        end else begin
          roll = $urandom_range(0, 99);
          if (roll < 4) kind = REQ_UNKNOWN;
          else if (roll < insert_pct) kind = REQ_INSERT;
          else kind = REQ_LOOKUP;
        end
        // mostly pool keys so lookups hit; the odd fresh key misses
        tag = ($urandom_range(0, 15) == 0) ? {$urandom, $urandom}
                                           : key_pool[$urandom_range(0, pool_n - 1)];
        send_req(kind, tag, $urandom);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);

    $display("Run covered %0d requests, %0d results checked, %0d limit settings;",
             reqs_sent, checked, limits_set);
    $display("%0d lookup hits, %0d entries evicted or cleared, peak occupancy %0d.",
             hits, evicted, peak);
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/lpc_pkg.sv
design/lpc_cell.sv
design/lru_plan_cache_top.sv
bench/lru_plan_cache_checker.sv
bench/lru_plan_cache_top_tb.sv
